@@ hw/rtl/itp_pkg.sv @@
package itp_pkg;

    localparam int SYM_W  = 8;
    localparam int CNT_W  = 6;
    localparam int STAT_W = 2;

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNF = 2'd2;

    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic              sym_valid;
        logic [STAT_W-1:0] status;
        logic              last;
    } result_t;

    function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_CARET) begin
            p = 2'd3;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end
        return p;
    endfunction

    function automatic logic is_alnum(input logic [SYM_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_opener(input logic [SYM_W-1:0] c);
        return c == CH_LBRACE || c == CH_LBRACK || c == CH_LPAREN;
    endfunction

    function automatic logic is_closer(input logic [SYM_W-1:0] c);
        return c == CH_RBRACE || c == CH_RBRACK || c == CH_RPAREN;
    endfunction

    function automatic logic [SYM_W-1:0] match_of(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] m;
        if (c == CH_RBRACE) begin
            m = CH_LBRACE;
        end else if (c == CH_RBRACK) begin
            m = CH_LBRACK;
        end else begin
            m = CH_LPAREN;
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/itp_ram.sv @@
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/itp_out.sv @@
module itp_out
    import itp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res_in,
    output logic        out_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_symbol, [9:8] status, [15:10] zero
    output logic        m_tuser,   // [0] symbol_valid
    output logic        m_tlast
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.status, res_reg.sym};
    assign m_tuser  = res_reg.sym_valid;
    assign m_tlast  = res_reg.last;

endmodule

@@ hw/rtl/infix_to_postfix_converter.sv @@
// Channel  Dir  tdata                       tuser          tlast
// s_       in   [7:0] symbol                [0] opcode     -
// m_       out  [7:0] out_symbol,[9:8] stat [0] sym_valid  last result of item
// cfg_wr   in   [5:0] stack_limit           -              -
//
// An item is taken in ST_IDLE, where the stack top is read; ST_EVAL then pops
// the operators one per step and finishes with a last step. The stack memory
// reads one entry a cycle through a registered read port, which sets the pace.
// Reset clears the fill count and the state machine and sets stack_limit to 32;
// the stack memory is not cleared. A full output register holds the sequencer.
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_symbol, [9:8] status, [15:10] zero
    output logic        m_tuser,   // [0] symbol_valid
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CAP = CNT_W'((STACK_DEPTH < 32) ? STACK_DEPTH : 32);

    typedef enum logic {ST_IDLE, ST_EVAL} state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  limit_reg;
    logic              op_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [SYM_W-1:0]  pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;

    logic [SYM_W-1:0]  top;
    logic [CNT_W-1:0]  eff_limit;
    logic [CNT_W-1:0]  cnt_dec;
    logic [1:0]        prec_top, prec_in;
    logic              nonempty, pop;
    logic              wr_en;
    logic              out_free, res_load;
    result_t           res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign eff_limit = (limit_reg > CAP) ? CAP : limit_reg;
    assign nonempty  = (count_reg != '0);
    assign prec_top  = prec_of(top);
    assign prec_in   = prec_of(sym_reg);

    always_comb begin
        if (op_reg == OP_FLUSH) begin
            pop = nonempty;
        end else if (is_alnum(sym_reg) || is_opener(sym_reg)) begin
            pop = 1'b0;
        end else if (is_closer(sym_reg)) begin
            pop = nonempty && (top != match_of(sym_reg));
        end else begin
            // equal precedence pops only when the incoming symbol is '^'
            pop = nonempty && ((prec_top > prec_in) ||
                               (prec_top == prec_in && sym_reg == CH_CARET));
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        wr_en           = 1'b0;
        res_load        = 1'b0;
        res             = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    if (pop) begin
                        // popped entry waits in pend_reg so its last flag is known
                        if (pend_valid_reg) begin
                            res_load      = 1'b1;
                            res.sym       = pend_reg;
                            res.sym_valid = 1'b1;
                        end
                        pend_next       = top;
                        pend_valid_next = 1'b1;
                        count_next      = count_reg - 1'b1;
                    end else begin
                        state_next      = ST_IDLE;
                        pend_valid_next = 1'b0;
                        res_load        = 1'b1;
                        res.last        = 1'b1;
                        res.status      = STAT_OK;
                        if (op_reg == OP_CHAR && is_closer(sym_reg)) begin
                            if (!nonempty) begin
                                res.status = STAT_UNF;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end else if (op_reg == OP_CHAR && !is_alnum(sym_reg)) begin
                            if (count_reg >= eff_limit) begin
                                res.status = STAT_OVF;
                                count_next = '0;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        if (pend_valid_reg) begin
                            res.sym       = pend_reg;
                            res.sym_valid = 1'b1;
                        end else if (op_reg == OP_CHAR && is_alnum(sym_reg)) begin
                            res.sym       = sym_reg;
                            res.sym_valid = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            limit_reg      <= CNT_W'(32);
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tuser;
            sym_reg <= s_tdata;
        end
        pend_reg <= pend_next;
    end

    // read address always points at the top of the stack as count_next leaves it
    assign cnt_dec = count_next - 1'b1;

    itp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (sym_reg),
        .rd_addr (cnt_dec[AW-1:0]),
        .rd_data (top)
    );

    itp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res_in   (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("stack count beyond capacity");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("popped symbol left behind between items");

    a_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata[9:8] == STAT_OK)
        else $error("non-final result without a symbol or with status");

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_EVAL)
        else $error("accepted request not evaluated");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam int MAX_OUT     = 32;
    localparam int RAND_TARGET = 210;

    typedef struct packed {
        logic             is_cfg;
        logic             op;
        logic [SYM_W-1:0] sym;
        logic [5:0]       lim;
    } req_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [5:0]  cfg_wr_data = 6'd0;

    req_t    pending_reqs[$];
    result_t postfix_exp[$];
    result_t item_out[$];

    // predictor state
    logic [SYM_W-1:0] op_stack[32];
    int               stack_fill = 0;
    logic [5:0]       limit_reg  = 6'd32;

    int n_pred    = 0;
    int n_seen    = 0;
    int errs      = 0;
    int cyc       = 0;
    int quiet_cnt = 0;
    int req_count = 0;

    logic [SYM_W-1:0] oper_set[5] = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS};
    logic [SYM_W-1:0] openers[3]  = '{CH_LBRACE, CH_LBRACK, CH_LPAREN};
    logic [SYM_W-1:0] closers[3]  = '{CH_RBRACE, CH_RBRACK, CH_RPAREN};

    infix_to_postfix_converter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [1:0] rank(input logic [SYM_W-1:0] c);
        case (c)
            CH_CARET:           return 2'd3;
            CH_STAR, CH_SLASH:  return 2'd2;
            CH_PLUS, CH_MINUS:  return 2'd1;
            default:            return 2'd0;
        endcase
    endfunction

    function automatic logic idle_now();
        // quiet window: neither side stalls
        if (cyc >= 300 && cyc < 600) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 25;
    endfunction

    task automatic pop_to_out();
        result_t r;
        r.sym       = op_stack[stack_fill-1];
        r.sym_valid = 1'b1;
        r.status    = STAT_OK;
        r.last      = 1'b0;
        if (item_out.size() < MAX_OUT) begin
            item_out.push_back(r);
        end
        stack_fill--;
    endtask

    function automatic logic [STAT_W-1:0] push_sym(input logic [SYM_W-1:0] c);
        int cap;
        cap = (limit_reg > 32) ? 32 : int'(limit_reg);
        if (stack_fill >= cap) begin
            stack_fill = 0;
            return STAT_OVF;
        end
        op_stack[stack_fill] = c;
        stack_fill++;
        return STAT_OK;
    endfunction

    task automatic predict_postfix(input logic op, input logic [SYM_W-1:0] c, output int n);
        logic [STAT_W-1:0] st;
        logic [SYM_W-1:0]  mate;
        result_t           r;
        st = STAT_OK;
        if (op == OP_FLUSH) begin
            while (stack_fill > 0) pop_to_out();
        end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                     (c >= "0" && c <= "9")) begin
            r.sym       = c;
            r.sym_valid = 1'b1;
            r.status    = STAT_OK;
            r.last      = 1'b0;
            item_out.push_back(r);
        end else if (c == CH_LBRACE || c == CH_LBRACK || c == CH_LPAREN) begin
            st = push_sym(c);
        end else if (c == CH_RBRACE || c == CH_RBRACK || c == CH_RPAREN) begin
            mate = (c == CH_RBRACE) ? CH_LBRACE : (c == CH_RBRACK) ? CH_LBRACK : CH_LPAREN;
            // other openers met on the way are emitted as ordinary characters
            while (stack_fill > 0 && op_stack[stack_fill-1] != mate) pop_to_out();
            if (stack_fill == 0) begin
                st = STAT_UNF;
            end else begin
                stack_fill--;
            end
        end else begin
            while (stack_fill > 0 && (rank(op_stack[stack_fill-1]) > rank(c) ||
                   (rank(op_stack[stack_fill-1]) == rank(c) && c == CH_CARET)))
                pop_to_out();
            st = push_sym(c);
        end
        if (item_out.size() == 0) begin
            r = '0;
            item_out.push_back(r);
        end
        r = item_out.pop_back();
        r.status = st;
        r.last   = 1'b1;
        item_out.push_back(r);
        n = item_out.size();
        while (item_out.size() > 0) postfix_exp.push_back(item_out.pop_front());
    endtask

    task automatic add_char(input logic [SYM_W-1:0] c);
        req_t r;
        r.is_cfg = 1'b0;
        r.op     = OP_CHAR;
        r.sym    = c;
        r.lim    = '0;
        pending_reqs.push_back(r);
        req_count++;
    endtask

    task automatic add_flush();
        req_t r;
        r.is_cfg = 1'b0;
        r.op     = OP_FLUSH;
        r.sym    = SYM_W'($urandom_range(0, 255));
        r.lim    = '0;
        pending_reqs.push_back(r);
        req_count++;
    endtask

    task automatic add_cfg(input logic [5:0] v);
        req_t r;
        r.is_cfg = 1'b1;
        r.op     = OP_CHAR;
        r.sym    = '0;
        r.lim    = v;
        pending_reqs.push_back(r);
    endtask

    // mostly well-formed nested expressions, with some noise and broken brackets
    task automatic gen_expr(input int depth);
        int terms;
        int k;
        int b;
        int cat;
        terms = $urandom_range(1, 4);
        for (k = 0; k < terms; k++) begin
            if (k > 0) add_char(oper_set[$urandom_range(0, 4)]);
            if ($urandom_range(0, 99) < 6) add_char(SYM_W'($urandom_range(0, 255)));
            if (depth > 0 && $urandom_range(0, 99) < 35) begin
                b = $urandom_range(0, 2);
                add_char(openers[b]);
                gen_expr(depth - 1);
                cat = $urandom_range(0, 99);
                if (cat < 8) begin
                    add_char(closers[$urandom_range(0, 2)]);
                end else if (cat >= 12) begin
                    add_char(closers[b]);
                end
            end else begin
                cat = $urandom_range(0, 2);
                if (cat == 0) begin
                    add_char(SYM_W'($urandom_range(8'h41, 8'h5A)));
                end else if (cat == 1) begin
                    add_char(SYM_W'($urandom_range(8'h61, 8'h7A)));
                end else begin
                    add_char(SYM_W'($urandom_range(8'h30, 8'h39)));
                end
            end
        end
    endtask

    // stimulus plan and end of run
    initial begin
        int i;
        int p;
        int phase_start;
        logic [5:0] phase_lims[6];

        // directed: precedence, brackets, caret rule, flush
        add_cfg(6'd32);
        add_char("A");  add_char(CH_PLUS);  add_char("z");  add_char(CH_STAR);
        add_char(CH_LPAREN); add_char("0"); add_char(CH_MINUS); add_char("9");
        add_char(CH_RPAREN); add_char(CH_CARET); add_char("x"); add_char(CH_CARET);
        add_char(CH_SLASH); add_flush();
        add_char(CH_RPAREN);
        add_char(CH_LBRACK); add_char(CH_LBRACE); add_char(CH_PLUS); add_char(CH_RBRACK);
        add_char(CH_STAR); add_char(CH_RBRACE);
        add_char(8'h00); add_char(8'hFF); add_char(CH_LBRACE);
        add_flush(); add_flush();
        // tiny limits, overflow
        add_cfg(6'd1);
        add_char(CH_LPAREN); add_char(CH_PLUS); add_char(CH_MINUS); add_flush();
        add_cfg(6'd0);
        add_char("a"); add_char(CH_CARET); add_flush();
        // limit lowered under a filled stack
        add_cfg(6'd32);
        add_char(CH_LPAREN); add_char(CH_LBRACK); add_char(CH_LBRACE); add_char(CH_CARET);
        add_cfg(6'd2);
        add_char("b"); add_char(CH_STAR); add_flush();

        // fill the whole stack, flush it, then overflow at the top
        add_cfg(6'd63);
        for (i = 0; i < 32; i++) add_char(openers[$urandom_range(0, 2)]);
        add_flush();
        for (i = 0; i < 33; i++) add_char(openers[$urandom_range(0, 2)]);
        add_char(CH_LPAREN);
        add_flush();

        phase_lims = '{6'd5, 6'd63, 6'd1, 6'd32, 6'd12, 6'd0};
        phase_lims[5] = 6'($urandom_range(0, 63));
        p = 0;
        while (req_count < RAND_TARGET) begin
            add_cfg(phase_lims[p % 6]);
            phase_start = req_count;
            while (req_count - phase_start < 30) begin
                gen_expr(3);
                if ($urandom_range(0, 99) < 90) add_flush();
            end
            p++;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (pending_reqs.size() > 0 || s_tvalid || n_pred != n_seen);
        repeat (40) @(negedge aclk);
        if (errs == 0 && postfix_exp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // driver
    always @(posedge aclk) begin : drv
        logic       nv;
        logic [7:0] nd;
        logic       nu;
        logic       ncfg;
        logic [5:0] ncd;
        logic       taken;
        int         k;
        req_t       r;
        nv   = s_tvalid;
        nd   = s_tdata;
        nu   = s_tuser;
        ncfg = 1'b0;
        ncd  = cfg_wr_data;
        if (!aresetn) begin
            nv = 1'b0;
            quiet_cnt = 0;
        end else begin
            taken = s_tvalid && s_tready;
            if (taken) begin
                predict_postfix(s_tuser, s_tdata, k);
                n_pred <= n_pred + k;
            end
            // block must be drained before the register changes
            if (!s_tvalid && !cfg_wr_en && n_pred == n_seen) begin
                quiet_cnt++;
            end else begin
                quiet_cnt = 0;
            end
            if (!s_tvalid || taken) begin
                nv = 1'b0;
                if (pending_reqs.size() > 0) begin
                    if (pending_reqs[0].is_cfg) begin
                        if (quiet_cnt >= SETTLE) begin
                            r = pending_reqs.pop_front();
                            ncfg = 1'b1;
                            ncd = r.lim;
                            limit_reg = r.lim;
                            quiet_cnt = 0;
                        end
                    end else if (!idle_now()) begin
                        r = pending_reqs.pop_front();
                        nv = 1'b1;
                        nd = r.sym;
                        nu = r.op;
                    end
                end
            end
        end
        s_tvalid    <= nv;
        s_tdata     <= nd;
        s_tuser     <= nu;
        cfg_wr_en   <= ncfg;
        cfg_wr_data <= ncd;
    end

    // monitor
    always @(posedge aclk) begin : mon
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.sym       = m_tdata[7:0];
                got.status    = m_tdata[9:8];
                got.sym_valid = m_tuser;
                got.last      = m_tlast;
                if (postfix_exp.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result: sym=%h valid=%b status=%0d last=%b",
                                 got.sym, got.sym_valid, got.status, got.last);
                end else begin
                    want = postfix_exp.pop_front();
                    n_seen <= n_seen + 1;
                    if (got !== want) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("mismatch: exp sym=%h valid=%b status=%0d last=%b,",
                                     want.sym, want.sym_valid, want.status, want.last);
                            $display("          got sym=%h valid=%b status=%0d last=%b",
                                     got.sym, got.sym_valid, got.status, got.last);
                        end
                    end
                end
            end
            m_tready <= !idle_now();
        end
    end

    always @(posedge aclk) begin : watchdog
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
hw/rtl/itp_pkg.sv
hw/rtl/itp_ram.sv
hw/rtl/itp_out.sv
hw/rtl/infix_to_postfix_converter.sv
tb/testbench.sv
